// ----- rtl/core/vertex_pair_dedup_table_unit_assert.svh -----
// Assertion macros used by the checker of the vertex pair dedup table unit.
`ifndef VERTEX_PAIR_DEDUP_TABLE_UNIT_ASSERT_SVH
`define VERTEX_PAIR_DEDUP_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vpd_pkg.sv -----
// Shared types and constants of the vertex pair dedup table unit.
package vpd_pkg;

  // Field widths of one corner and one result.
  localparam int unsigned IDX_W = 16;
  localparam int unsigned VID_W = 12;
  localparam int unsigned HASH_W = 32;

  // Input transaction layout.
  localparam int unsigned IN_DATA_W = 40;
  localparam int unsigned IN_RESTART_BIT = 0;
  localparam int unsigned IN_POS_LSB = 1;
  localparam int unsigned IN_TEX_LSB = IN_POS_LSB + IDX_W;

  // Output transaction layout.
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_VID_LSB = 0;
  localparam int unsigned OUT_NEW_BIT = VID_W;
  localparam int unsigned OUT_FULL_BIT = VID_W + 1;
  localparam int unsigned OUT_PAD_W = OUT_DATA_W - VID_W - 2;

  // Hash multipliers for the position and texture indexes.
  localparam logic [HASH_W-1:0] HASH_MUL_POS = 32'd393241;
  localparam logic [HASH_W-1:0] HASH_MUL_TEX = 32'd786433;

  // Lookup sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_INSERT,
    ST_LINK,
    ST_OUT
  } state_e;

endpackage

// ----- rtl/core/vpd_ram.sv -----
// Simple dual-port synchronous RAM with one write port and a registered read port.
module vpd_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/vpd_hash.sv -----
// Bucket hash: two constant products, XOR, then reduction modulo the bucket count.
module vpd_hash #(
  parameter int unsigned BUCKETS = 1024,
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [vpd_pkg::IDX_W-1:0] pos_i,
  input  logic [vpd_pkg::IDX_W-1:0] tex_i,
  output logic                      done_o,
  output logic [BW-1:0]             bucket_o
);
  import vpd_pkg::*;

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic              mul_vld_q;
  logic [HASH_W-1:0] prod_pos_q;
  logic [HASH_W-1:0] prod_tex_q;
  logic [HASH_W-1:0] hash_w;

  // Product stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
    end
  end

  // Both products with 32-bit wrap, registered before the XOR.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_pos_q <= HASH_W'(HASH_W'(pos_i) * HASH_MUL_POS);
      prod_tex_q <= HASH_W'(HASH_W'(tex_i) * HASH_MUL_TEX);
    end
  end

  assign hash_w = prod_pos_q ^ prod_tex_q;

  if (POW2) begin : gen_pow2
    // A power-of-two bucket count only keeps the low bits.
    assign done_o   = mul_vld_q;
    assign bucket_o = (BUCKETS == 1) ? '0 : hash_w[BW-1:0];
  end else begin : gen_recip
    // Reciprocal reduction: the estimated quotient is at most one short, so
    // the low bits of the raw remainder and one compare and subtract suffice.
    localparam int unsigned RW = BW + 1;
    localparam int unsigned PW = 2 * HASH_W;
    localparam longint unsigned RECIP = (64'd1 << HASH_W) / BUCKETS;
    localparam logic [HASH_W-1:0] RECIP_C = HASH_W'(RECIP);
    localparam logic [RW-1:0] BUCKETS_C = RW'(BUCKETS);

    logic              quot_vld_q;
    logic              rem_vld_q;
    logic [HASH_W-1:0] quot_q;
    logic [RW-1:0]     h_low_q;
    logic [RW-1:0]     rem_q;
    logic [PW-1:0]     recip_prod;
    logic [RW-1:0]     rem_raw;

    assign recip_prod = PW'(hash_w) * PW'(RECIP_C);
    assign rem_raw    = h_low_q - quot_q[RW-1:0] * BUCKETS_C;
    assign done_o     = rem_vld_q;
    assign bucket_o   = (rem_q >= BUCKETS_C) ? BW'(rem_q - BUCKETS_C) : rem_q[BW-1:0];

    // Stage valid flags.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        quot_vld_q <= 1'b0;
        rem_vld_q  <= 1'b0;
      end else begin
        quot_vld_q <= mul_vld_q;
        rem_vld_q  <= quot_vld_q;
      end
    end

    // Estimated quotient, then the raw remainder below twice the bucket count.
    always_ff @(posedge clk_i) begin
      if (mul_vld_q) begin
        quot_q  <= recip_prod[PW-1:HASH_W];
        h_low_q <= hash_w[RW-1:0];
      end
      if (quot_vld_q) begin
        rem_q <= rem_raw;
      end
    end
  end

endmodule

// ----- rtl/core/vertex_pair_dedup_table_unit.sv -----
// Top level of the vertex pair dedup table: lookup sequencer and its two memories.
//
// Each input transaction carries one face corner (restart flag, position index,
// texture index); each output transaction returns the corner's vertex id with a
// new flag and a table full flag. Ids are handed out in first-seen order.
// One item is processed at a time. An item is hashed, its bucket head is read and
// its chain is walked, one entry memory read per chain entry, until a hit or the
// chain's end; a new pair is then inserted if room is left, and an insert behind
// an existing chain adds a tail link write. A BUCKETS that is not a power of
// two adds the quotient and remainder registers of the reciprocal reduction of
// the hash. The input reopens as the result is loaded into the output register,
// and the chain walk is set by the single read port of the entry memory.
// The input is accepted while a previous result still waits in the output
// register; a stalled receiver holds the result and the next result waits.
// Reset clears the sequencer, the output valid and the entry count, then a
// clearing pass zeroes every bucket head with the input closed.
// Afterwards a bucket head is only trusted when it points below the count at an
// entry tagged with that bucket, so a restart item only resets the count before
// its lookup.
module vertex_pair_dedup_table_unit #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: restart [0], position_index [16:1], texcoord_index [32:17], zero pad
  input  logic [vpd_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: vertex_id [11:0], was_new [12], table_full [13], zero pad
  output logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready
);
  import vpd_pkg::*;

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic [BW-1:0]    tag;
    logic             link_vld;
    logic [IW-1:0]    link;
    logic [IDX_W-1:0] tex;
    logic [IDX_W-1:0] pos;
  } entry_t;

  state_e state_q, state_d;

  logic [BW-1:0]    clr_q;
  logic [IDX_W-1:0] pos_q, tex_q;
  logic [BW-1:0]    bucket_q;
  logic [IW-1:0]    cur_q, tail_q, new_id_q;
  logic             have_tail_q, first_q;
  entry_t           tail_word_q;
  logic [CW-1:0]    count_q;
  logic [VID_W-1:0] res_vid_q;
  logic             res_new_q, res_full_q;
  logic             m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;

  logic          hash_start, hash_done;
  logic [BW-1:0] hash_bucket;
  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [IW-1:0] head_wdata, head_rdata;
  logic          entry_we;
  logic [IW-1:0] entry_waddr, entry_raddr;
  entry_t        entry_wdata, entry_rd, new_entry, tail_link;

  logic head_cand, head_miss, pair_hit, table_full, out_free;

  vpd_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .pos_i    (s_axis_tdata[IN_POS_LSB +: IDX_W]),
    .tex_i    (s_axis_tdata[IN_TEX_LSB +: IDX_W]),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  vpd_ram #(.DEPTH(BUCKETS), .WIDTH(IW)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  vpd_ram #(.DEPTH(MAX_ENTRIES), .WIDTH($bits(entry_t))) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_we),
    .waddr_i (entry_waddr),
    .wdata_i (entry_wdata),
    .raddr_i (entry_raddr),
    .rdata_o (entry_rd)
  );

  // Lookup decisions and the words written on insert.
  always_comb begin
    head_cand  = (CW'(head_rdata) < count_q);
    head_miss  = first_q && (entry_rd.tag != bucket_q);
    pair_hit   = !head_miss && (entry_rd.pos == pos_q) && (entry_rd.tex == tex_q);
    table_full = (count_q == CW'(MAX_ENTRIES));
    out_free   = !m_tvalid_q || m_axis_tready;

    new_entry          = '0;
    new_entry.tag      = bucket_q;
    new_entry.pos      = pos_q;
    new_entry.tex      = tex_q;

    tail_link          = tail_word_q;
    tail_link.link_vld = 1'b1;
    tail_link.link     = new_id_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == BW'(BUCKETS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_HASH;
      ST_HASH:   if (hash_done) state_d = ST_HEAD;
      ST_HEAD:   state_d = head_cand ? ST_WALK : ST_INSERT;
      ST_WALK: begin
        if (head_miss) begin
          state_d = ST_INSERT;
        end else if (pair_hit) begin
          state_d = ST_OUT;
        end else if (!entry_rd.link_vld) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: state_d = (table_full || !have_tail_q) ? ST_OUT : ST_LINK;
      ST_LINK:   state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    hash_start    = 1'b0;
    head_we       = 1'b0;
    head_waddr    = bucket_q;
    head_wdata    = new_id_q;
    head_raddr    = hash_bucket;
    entry_we      = 1'b0;
    entry_waddr   = count_q[IW-1:0];
    entry_wdata   = new_entry;
    entry_raddr   = head_rdata;
    case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
      end
      ST_IDLE: hash_start = s_axis_tvalid;
      ST_WALK: entry_raddr = entry_rd.link;
      ST_INSERT: begin
        if (!table_full) begin
          entry_we   = 1'b1;
          head_we    = !have_tail_q;
          head_wdata = count_q[IW-1:0];
        end
      end
      ST_LINK: begin
        entry_we    = 1'b1;
        entry_waddr = tail_q;
        entry_wdata = tail_link;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tdata[IN_RESTART_BIT]) begin
        count_q <= '0;
      end else if (state_q == ST_INSERT && !table_full) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          pos_q       <= s_axis_tdata[IN_POS_LSB +: IDX_W];
          tex_q       <= s_axis_tdata[IN_TEX_LSB +: IDX_W];
          have_tail_q <= 1'b0;
        end
      end
      ST_HASH: begin
        if (hash_done) bucket_q <= hash_bucket;
      end
      ST_HEAD: begin
        cur_q   <= head_rdata;
        first_q <= 1'b1;
      end
      ST_WALK: begin
        if (pair_hit) begin
          res_vid_q  <= VID_W'(cur_q);
          res_new_q  <= 1'b0;
          res_full_q <= 1'b0;
        end else if (!head_miss) begin
          tail_q      <= cur_q;
          tail_word_q <= entry_rd;
          have_tail_q <= 1'b1;
          cur_q       <= entry_rd.link;
          first_q     <= 1'b0;
        end
      end
      ST_INSERT: begin
        new_id_q <= count_q[IW-1:0];
        if (table_full) begin
          res_vid_q  <= '0;
          res_new_q  <= 1'b0;
          res_full_q <= 1'b1;
        end else begin
          res_vid_q  <= VID_W'(count_q);
          res_new_q  <= 1'b1;
          res_full_q <= 1'b0;
        end
      end
      ST_OUT: begin
        if (out_free) m_tdata_q <= {OUT_PAD_W'(0), res_full_q, res_new_q, res_vid_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// ----- rtl/core/vpd_checker.sv -----
// Port-level checker for the vertex pair dedup table unit, bound to the top level.
`include "vertex_pair_dedup_table_unit_assert.svh"

module vpd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [vpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready
);
  import vpd_pkg::*;

  // A result is never both new and rejected for lack of space.
  `VPD_ASSERT_SAME(a_flags_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[OUT_NEW_BIT] && m_axis_tdata[OUT_FULL_BIT]), "new and full flags both set")

  // A full table reports vertex id zero.
  `VPD_ASSERT_SAME(a_full_id_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[OUT_FULL_BIT], m_axis_tdata[OUT_VID_LSB +: VID_W] == '0, "full result with nonzero id")

  // A stalled result stays valid and unchanged.
  `VPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Only one corner is in flight: the input closes after each transaction.
  `VPD_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open right after a transaction")

endmodule

bind vertex_pair_dedup_table_unit vpd_checker u_vpd_checker (.*);

// ----- tb/tb_vertex_pair_dedup_table_unit.sv -----
// Self-checking testbench for the vertex pair dedup table unit with its own id predictor.
module tb_vertex_pair_dedup_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import vpd_pkg::*;

  localparam int unsigned BUCKET_COUNT = 1024;
  localparam int unsigned ENTRY_LIMIT = 4096;
  localparam int unsigned RANDOM_HALF = 590;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned REPORT_LIMIT = 10;

  // One face corner waiting to be sent, with an optional wait for the pipeline to empty.
  typedef struct {
    logic        restart;
    logic [15:0] pos;
    logic [15:0] tex;
    bit          drain;
  } corner_t;

  // One result transaction as the block reports it.
  typedef struct packed {
    logic             table_full;
    logic             was_new;
    logic [VID_W-1:0] vertex_id;
  } vertex_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;

  corner_t        corner_q[$];
  vertex_result_t expected_vertex_q[$];
  bit [31:0]      seen_pairs[$];

  // Predictor state: ids of stored pairs keyed by {position, texcoord}.
  int unsigned pair_id[bit [31:0]];
  int unsigned stored_count = 0;

  int unsigned err_count = 0;
  int unsigned cyc = 0;
  bit          in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  vertex_pair_dedup_table_unit #(
    .BUCKETS(BUCKET_COUNT),
    .MAX_ENTRIES(ENTRY_LIMIT)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #6 clk_i = ~clk_i;

  // Predict one corner's result: restart clears, a known pair hits, a new pair is stored if room is left.
  function automatic vertex_result_t lookup_vertex(logic restart, logic [15:0] p, logic [15:0] t);
    vertex_result_t r;
    bit [31:0]      key;
    key = {p, t};
    r = '0;
    if (restart) begin
      pair_id.delete();
      stored_count = 0;
    end
    if (pair_id.exists(key)) begin
      r.vertex_id = VID_W'(pair_id[key]);
    end else if (stored_count >= ENTRY_LIMIT) begin
      r.table_full = 1'b1;
    end else begin
      pair_id[key] = stored_count;
      r.vertex_id = VID_W'(stored_count);
      r.was_new = 1'b1;
      stored_count = stored_count + 1;
    end
    return r;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_idle(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_mismatch(string what, vertex_result_t want, vertex_result_t got);
    err_count++;
    if (err_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected id %0d new %0b full %0b, got id %0d new %0b full %0b",
               $realtime, what, want.vertex_id, want.was_new, want.table_full,
               got.vertex_id, got.was_new, got.table_full);
    end
  endtask

  task automatic add_corner(logic restart, logic [15:0] p, logic [15:0] t, bit drain);
    corner_t c;
    c.restart = restart;
    c.pos = p;
    c.tex = t;
    c.drain = drain;
    corner_q.push_back(c);
    if (seen_pairs.size() < 512) seen_pairs.push_back({p, t});
  endtask

  // Random segments: mixes of new and repeated pairs, bucket collision groups, restarts, drain waits.
  task automatic random_segments(int unsigned count);
    int unsigned target;
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    bit [31:0]   pick;
    logic [9:0]  base;
    logic [15:0] tex;
    target = corner_q.size() + count;
    while (corner_q.size() < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        n = $urandom_range(10, 50);
        repeat (n) begin
          if (seen_pairs.size() != 0 && $urandom_range(0, 1) == 1) begin
            pick = seen_pairs[$urandom_range(0, seen_pairs.size() - 1)];
          end else begin
            pick = $urandom;
          end
          add_corner($urandom_range(0, 99) == 0, pick[31:16], pick[15:0], 1'b0);
        end
      end else if (kind < 8) begin
        // Positions that differ only above bit 9 land in one bucket and build a long chain.
        base = 10'($urandom);
        tex = 16'($urandom);
        n = $urandom_range(4, 40);
        repeat (n) begin
          k = $urandom_range(0, 63);
          add_corner(1'b0, {k[5:0], base}, tex, 1'b0);
        end
      end else if (kind == 8) begin
        pick = $urandom;
        add_corner(1'b1, pick[31:16], pick[15:0], 1'b0);
      end else begin
        pick = $urandom;
        add_corner(1'b0, pick[31:16], pick[15:0], 1'b1);
      end
    end
  endtask

  // Input and output sampling: predictor on accepted corners, checker on accepted results.
  always @(posedge clk_i) begin
    vertex_result_t got;
    vertex_result_t want;
    cyc <= cyc + 1;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vertex_q.push_back(lookup_vertex(s_axis_tdata[IN_RESTART_BIT],
                                                  s_axis_tdata[IN_POS_LSB +: IDX_W],
                                                  s_axis_tdata[IN_TEX_LSB +: IDX_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.vertex_id = m_axis_tdata[OUT_VID_LSB +: VID_W];
        got.was_new = m_axis_tdata[OUT_NEW_BIT];
        got.table_full = m_axis_tdata[OUT_FULL_BIT];
        if (expected_vertex_q.size() == 0) begin
          note_mismatch("result with nothing outstanding", '0, got);
        end else begin
          want = expected_vertex_q.pop_front();
          if (got.vertex_id !== want.vertex_id || got.was_new !== want.was_new ||
              got.table_full !== want.table_full) begin
            note_mismatch("vertex result mismatch", want, got);
          end
        end
      end
    end
  end

  // Corner driver: presents the next queued corner after its gap, holding it until accepted.
  always @(negedge clk_i) begin
    corner_t c;
    logic [IN_DATA_W-1:0] d;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (corner_q.size() != 0 &&
                   !(corner_q[0].drain && expected_vertex_q.size() != 0)) begin
        c = corner_q.pop_front();
        d = '0;
        d[IN_RESTART_BIT] = c.restart;
        d[IN_POS_LSB +: IDX_W] = c.pos;
        d[IN_TEX_LSB +: IDX_W] = c.tex;
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        send_gap <= pick_idle(((cyc >> 11) % 4) == 0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure stretches.
  always @(negedge clk_i) begin
    if (recv_gap != 0) begin
      m_axis_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap <= pick_idle(((cyc >> 11) % 4) == 1);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed corners: extremes, zero indexes, bucket collisions, repeats and restarts.
    add_corner(1'b0, 16'd1, 16'd1, 1'b0);
    add_corner(1'b0, 16'd1, 16'd1, 1'b0);
    add_corner(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    add_corner(1'b0, 16'd0, 16'd0, 1'b0);
    add_corner(1'b0, 16'd0, 16'hFFFF, 1'b0);
    add_corner(1'b0, 16'hFFFF, 16'd0, 1'b0);
    add_corner(1'b0, 16'd1025, 16'd1, 1'b0);
    add_corner(1'b0, 16'd1, 16'd1025, 1'b0);
    add_corner(1'b0, 16'd2049, 16'd1, 1'b0);
    add_corner(1'b0, 16'd1, 16'd1, 1'b0);
    add_corner(1'b0, 16'd1025, 16'd1, 1'b0);
    add_corner(1'b0, 16'd2049, 16'd1, 1'b0);
    add_corner(1'b0, 16'd0, 16'd0, 1'b0);
    add_corner(1'b1, 16'd1, 16'd1, 1'b0);
    add_corner(1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    add_corner(1'b0, 16'd1, 16'd1, 1'b0);
    add_corner(1'b1, 16'd2, 16'd2, 1'b0);
    add_corner(1'b1, 16'd2, 16'd2, 1'b0);
    add_corner(1'b0, 16'd2, 16'd2, 1'b1);
    add_corner(1'b0, 16'hAAAA, 16'h5555, 1'b0);
    add_corner(1'b0, 16'h5555, 16'hAAAA, 1'b0);

    random_segments(RANDOM_HALF);
    random_segments(RANDOM_HALF);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (corner_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_vertex_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/vpd_pkg.sv
rtl/core/vpd_ram.sv
rtl/core/vpd_hash.sv
rtl/core/vertex_pair_dedup_table_unit.sv
rtl/core/vpd_checker.sv
tb/tb_vertex_pair_dedup_table_unit.sv
